/* sv/jdc_pkg.sv */
// Shared constants, types and lookup functions for the Julian day to calendar
// date converter. No dependencies; every design file imports this package.
package jdc_pkg;

  // Pipeline depth and the stage that each part of the work occupies.
  localparam int STAGES       = 8;
  localparam int ST_GREG_MUL  = 0;
  localparam int ST_GREG_FIX  = 1;
  localparam int ST_YEAR_MUL  = 2;
  localparam int ST_YEAR_FIX  = 3;
  localparam int ST_DAY_OFS   = 4;
  localparam int ST_MON_MUL   = 5;
  localparam int ST_MON_FIX   = 6;
  localparam int ST_OUT       = 7;
  localparam int ST_HOUR      = 0;
  localparam int ST_MINUTE    = 1;
  localparam int ST_SECOND    = 2;

  localparam int DAY_W  = 22;
  localparam int FRAC_W = 32;
  localparam int JJ_W   = 23;
  localparam int K_W    = 14;
  localparam int D_W    = 9;

  // Calendar switch and Gregorian century correction.
  localparam logic [DAY_W-1:0] SWITCH_DAY  = 22'd2299161;
  // 2268993 minus the ten-day shift that is applied first.
  localparam logic [DAY_W-1:0] CENTURY_OFS = 22'd2268983;
  // 36524.25 days per century, as 4 * x / 146097.
  localparam logic [17:0]      CENT_DIV    = 18'd146097;
  localparam logic [5:0]       CENT_RECIP  = 6'd57;      // floor(2^23 / 146097)
  localparam int               CENT_SHIFT  = 23;

  // 365.25 days per year, as 4 * x / 1461.
  localparam logic [10:0]      YEAR_DIV    = 11'd1461;
  localparam logic [14:0]      YEAR_RECIP  = 15'd22966;  // floor(2^25 / 1461)
  localparam int               YEAR_SHIFT  = 25;
  localparam logic [12:0]      YEAR_BASE   = 13'd4712;
  localparam logic [D_W-1:0]   MARCH_OFS   = 9'd59;

  // 30.61 days per month, as 100 * x / 3061.
  localparam logic [11:0]      MON_DIV     = 12'd3061;
  localparam logic [4:0]       MON_RECIP   = 5'd21;      // floor(2^16 / 3061)
  localparam int               MON_SHIFT   = 16;
  localparam logic [9:0]       MON_BIAS    = 10'd64;
  localparam logic [6:0]       MON_SCALE   = 7'd100;
  localparam logic [4:0]       MONTHS      = 5'd12;

  // Gregorian correction results handed from the first stages onward.
  typedef struct packed {
    logic [DAY_W-1:0] j;
    logic             greg;
    logic [5:0]       a;
  } jdc_greg_t;

  // Day offset in the March-based year and the reported year.
  typedef struct packed {
    logic [D_W-1:0] d;
    logic [12:0]    year;
  } jdc_date_t;

  // floor(30.61 * q), the day count up to the start of month index q.
  function automatic logic [9:0] month_start(input logic [4:0] q);
    logic [9:0] v;
    unique case (q)
      5'd0:  v = 10'd0;
      5'd1:  v = 10'd30;
      5'd2:  v = 10'd61;
      5'd3:  v = 10'd91;
      5'd4:  v = 10'd122;
      5'd5:  v = 10'd153;
      5'd6:  v = 10'd183;
      5'd7:  v = 10'd214;
      5'd8:  v = 10'd244;
      5'd9:  v = 10'd275;
      5'd10: v = 10'd306;
      5'd11: v = 10'd336;
      5'd12: v = 10'd367;
      5'd13: v = 10'd397;
      5'd14: v = 10'd428;
      5'd15: v = 10'd459;
      5'd16: v = 10'd489;
      5'd17: v = 10'd520;
      5'd18: v = 10'd550;
      5'd19: v = 10'd581;
      5'd20: v = 10'd612;
      5'd21: v = 10'd642;
      5'd22: v = 10'd673;
      5'd23: v = 10'd704;
      5'd24: v = 10'd734;
      5'd25: v = 10'd765;
      5'd26: v = 10'd795;
      5'd27: v = 10'd826;
      5'd28: v = 10'd857;
      5'd29: v = 10'd887;
      5'd30: v = 10'd918;
      5'd31: v = 10'd948;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/jdc_greg.sv */
// Gregorian century correction, pipeline stages 0 and 1.
// Depends on jdc_pkg.
module jdc_greg (
  input  logic                        clk,
  input  logic [jdc_pkg::STAGES-1:0]  en,
  input  logic [jdc_pkg::DAY_W-1:0]   day_number,
  output jdc_pkg::jdc_greg_t          greg_o
);
  import jdc_pkg::*;

  logic [DAY_W-1:0] j_r0;
  logic             greg_r0;
  logic [22:0]      xa_r0;
  logic [28:0]      pa_r0;

  logic             greg_nxt;
  logic [22:0]      xa_nxt;
  logic [5:0]       qa;
  logic [23:0]      ra;
  logic [5:0]       a_nxt;

  jdc_greg_t        greg_r1;

  always_comb begin
    greg_nxt = (day_number >= SWITCH_DAY);
    xa_nxt   = greg_nxt ? {1'b0, day_number - CENTURY_OFS} << 2 : 23'd0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_GREG_MUL]) begin
      j_r0    <= day_number;
      greg_r0 <= greg_nxt;
      xa_r0   <= xa_nxt;
      pa_r0   <= xa_nxt * CENT_RECIP;
    end
  end

  // The reciprocal estimate is low by at most one; one compare corrects it.
  always_comb begin
    qa    = pa_r0[28:CENT_SHIFT];
    ra    = {1'b0, xa_r0} - 24'(qa) * 24'(CENT_DIV);
    a_nxt = (ra >= {6'd0, CENT_DIV}) ? qa + 6'd1 : qa;
  end

  always_ff @(posedge clk) begin
    if (en[ST_GREG_FIX]) begin
      greg_r1.j    <= j_r0;
      greg_r1.greg <= greg_r0;
      greg_r1.a    <= a_nxt;
    end
  end

  assign greg_o = greg_r1;

endmodule

/* sv/jdc_year.sv */
// Year estimate and day offset within the March-based year, stages 2 to 4.
// Depends on jdc_pkg.
module jdc_year (
  input  logic                        clk,
  input  logic [jdc_pkg::STAGES-1:0]  en,
  input  jdc_pkg::jdc_greg_t          greg_i,
  output jdc_pkg::jdc_date_t          date_o
);
  import jdc_pkg::*;

  logic [JJ_W-1:0] jj_nxt;
  logic [6:0]      a_corr;
  logic [JJ_W-1:0] jj_r2;
  logic [39:0]     pk_r2;

  logic [24:0]     xk;
  logic [14:0]     qk;
  logic [25:0]     rk;
  logic [K_W-1:0]  k_nxt;
  logic [K_W-1:0]  k_r3;
  logic [JJ_W-1:0] jj_r3;

  logic signed [26:0] prod;
  logic signed [26:0] jj_s;
  logic signed [26:0] d0;
  logic signed [26:0] d1;
  logic [D_W-1:0]     d_nxt;
  jdc_date_t          date_r4;

  always_comb begin
    a_corr = ({1'b0, greg_i.a} + 7'd3) >> 2;
    if (greg_i.greg) begin
      jj_nxt = {1'b0, greg_i.j} + 23'd10 + {17'd0, greg_i.a} - {16'd0, a_corr};
    end else begin
      jj_nxt = {1'b0, greg_i.j};
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_YEAR_MUL]) begin
      jj_r2 <= jj_nxt;
      pk_r2 <= {jj_nxt, 2'b00} * YEAR_RECIP;
    end
  end

  always_comb begin
    xk    = {jj_r2, 2'b00};
    qk    = pk_r2[39:YEAR_SHIFT];
    rk    = {1'b0, xk} - 26'(qk) * 26'(YEAR_DIV);
    k_nxt = (rk >= {15'd0, YEAR_DIV}) ? qk[K_W-1:0] + 14'd1 : qk[K_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_YEAR_FIX]) begin
      k_r3  <= k_nxt;
      jj_r3 <= jj_r2;
    end
  end

  // A day before 1 March of the estimated year is counted from the year
  // start before it; the arithmetic shift gives the floor for k equal to 0.
  always_comb begin
    prod  = signed'(27'(k_r3) * 27'(YEAR_DIV));
    jj_s  = signed'({4'd0, jj_r3});
    d0    = jj_s - (prod >>> 2) - 27'sd1;
    d1    = jj_s - ((prod - 27'sd1461) >>> 2) - 27'sd1;
    d_nxt = (d0 < 27'sd59) ? d1[D_W-1:0] : d0[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_DAY_OFS]) begin
      date_r4.d    <= d_nxt;
      date_r4.year <= k_r3[12:0] - YEAR_BASE;
    end
  end

  assign date_o = date_r4;

endmodule

/* sv/jdc_month.sv */
// Month and day of month from the day offset, stages 5 to 7.
// Depends on jdc_pkg.
module jdc_month (
  input  logic                        clk,
  input  logic [jdc_pkg::STAGES-1:0]  en,
  input  jdc_pkg::jdc_date_t          date_i,
  output logic [12:0]                 cal_year,
  output logic [3:0]                  cal_month,
  output logic [4:0]                  cal_day
);
  import jdc_pkg::*;

  logic [15:0]    xm_nxt;
  logic [15:0]    xm_r5;
  logic [20:0]    pm_r5;
  logic [D_W-1:0] d_r5;
  logic [12:0]    year_r5;

  logic [4:0]     qm;
  logic [16:0]    rm;
  logic [4:0]     q_nxt;
  logic [4:0]     q_r6;
  logic [D_W-1:0] d_r6;
  logic [12:0]    year_r6;

  logic [4:0]     m;
  logic [4:0]     month_nxt;
  logic [9:0]     day_nxt;
  logic [12:0]    year_r7;
  logic [3:0]     month_r7;
  logic [4:0]     day_r7;

  always_comb begin
    xm_nxt = 16'({1'b0, date_i.d} + MON_BIAS) * 16'(MON_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en[ST_MON_MUL]) begin
      xm_r5   <= xm_nxt;
      pm_r5   <= xm_nxt * MON_RECIP;
      d_r5    <= date_i.d;
      year_r5 <= date_i.year;
    end
  end

  always_comb begin
    qm    = pm_r5[20:MON_SHIFT];
    rm    = {1'b0, xm_r5} - 17'(qm) * 17'(MON_DIV);
    q_nxt = (rm >= {5'd0, MON_DIV}) ? qm + 5'd1 : qm;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MON_FIX]) begin
      q_r6    <= q_nxt;
      d_r6    <= d_r5;
      year_r6 <= year_r5;
    end
  end

  // Month indexes 13 and 14 fold back to January and February.
  always_comb begin
    m         = q_r6 - 5'd1;
    month_nxt = (m > MONTHS) ? m - MONTHS : m;
    day_nxt   = {1'b0, d_r6} + MON_BIAS - month_start(q_r6);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      year_r7  <= year_r6;
      month_r7 <= month_nxt[3:0];
      day_r7   <= day_nxt[4:0];
    end
  end

  assign cal_year  = year_r7;
  assign cal_month = month_r7;
  assign cal_day   = day_r7;

endmodule

/* sv/jdc_clock.sv */
// Time of day from the day fraction: hour, minute and second in stages 0
// to 2, then carried along to the output stage. Depends on jdc_pkg.
module jdc_clock (
  input  logic                        clk,
  input  logic [jdc_pkg::STAGES-1:0]  en,
  input  logic [jdc_pkg::FRAC_W-1:0]  day_fraction,
  output logic [4:0]                  clock_hour,
  output logic [5:0]                  clock_minute,
  output logic [5:0]                  clock_second
);
  import jdc_pkg::*;

  logic [36:0]       t1;
  logic [37:0]       t2;
  logic [37:0]       t3;
  logic [FRAC_W-1:0] frac1_r;
  logic [FRAC_W-1:0] frac2_r;

  logic [4:0] hour_r   [ST_HOUR:STAGES-1];
  logic [5:0] minute_r [ST_MINUTE:STAGES-1];
  logic [5:0] second_r [ST_SECOND:STAGES-1];

  always_comb begin
    t1 = day_fraction * 5'd24;
    t2 = frac1_r * 6'd60;
    t3 = frac2_r * 6'd60;
  end

  always_ff @(posedge clk) begin
    if (en[ST_HOUR]) begin
      hour_r[ST_HOUR] <= t1[36:32];
      frac1_r         <= t1[31:0];
    end
    if (en[ST_MINUTE]) begin
      minute_r[ST_MINUTE] <= t2[37:32];
      frac2_r             <= t2[31:0];
    end
    if (en[ST_SECOND]) begin
      second_r[ST_SECOND] <= t3[37:32];
    end
    for (int i = ST_HOUR + 1; i < STAGES; i++) begin
      if (en[i]) hour_r[i] <= hour_r[i-1];
    end
    for (int i = ST_MINUTE + 1; i < STAGES; i++) begin
      if (en[i]) minute_r[i] <= minute_r[i-1];
    end
    for (int i = ST_SECOND + 1; i < STAGES; i++) begin
      if (en[i]) second_r[i] <= second_r[i-1];
    end
  end

  assign clock_hour   = hour_r[STAGES-1];
  assign clock_minute = minute_r[STAGES-1];
  assign clock_second = second_r[STAGES-1];

endmodule

/* sv/julian_day_to_calendar_date_unit.sv */
// Top level of the Julian day to calendar date converter: stage valid bits,
// stall control and the four datapath parts. Depends on jdc_pkg.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    in_day_number[21:0], in_day_fraction[31:0]
//   out      out_valid/out_ready  out_cal_year[12:0], out_cal_month[3:0],
//                                 out_cal_day[4:0], out_clock_hour[4:0],
//                                 out_clock_minute[5:0], out_clock_second[5:0]
//
// One transaction can enter every cycle while the output side does not stall.
// Each passes in order through the multiply and correction stages of the
// century and year reciprocal divisions, the day offset stage, the multiply
// and correction stages of the month division and the output register.
// Reset (rst_n low, synchronous) clears only the stage valid bits. A stage
// holds its contents while the stage after it is full and stalled, so a
// stalled output lets bubbles further up close and new transactions keep
// entering until every stage is occupied.
module julian_day_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [21:0] in_day_number,
  input  logic [31:0] in_day_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_clock_hour,
  output logic [5:0]  out_clock_minute,
  output logic [5:0]  out_clock_second
);
  import jdc_pkg::*;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] up_valid;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] en;

  jdc_greg_t greg;
  jdc_date_t date;

  // A stage may load when it is empty or when its own content moves on.
  always_comb begin
    rdy[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
  end

  assign en       = rdy[STAGES-1:0];
  assign up_valid = {valid_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) valid_r[i] <= up_valid[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[STAGES-1];

  jdc_greg u_greg (
    .clk        (clk),
    .en         (en),
    .day_number (in_day_number),
    .greg_o     (greg)
  );

  jdc_year u_year (
    .clk    (clk),
    .en     (en),
    .greg_i (greg),
    .date_o (date)
  );

  jdc_month u_month (
    .clk       (clk),
    .en        (en),
    .date_i    (date),
    .cal_year  (out_cal_year),
    .cal_month (out_cal_month),
    .cal_day   (out_cal_day)
  );

  jdc_clock u_clock (
    .clk          (clk),
    .en           (en),
    .day_fraction (in_day_fraction),
    .clock_hour   (out_clock_hour),
    .clock_minute (out_clock_minute),
    .clock_second (out_clock_second)
  );

endmodule

/* tb/sv/tb.sv */
// Testbench for julian_day_to_calendar_date_unit: predicts the calendar date and
// the clock for every timestamp transaction and checks each result in order.
// Depends on the RTL top level (and through it jdc_pkg); reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Calendar constants used by the predictor, kept in exact integer form:
  // 365.25 = 1461/4, 36524.25 = 3652425/100 and 30.61 = 3061/100.
  localparam longint GREG_SWITCH    = 2299161;
  localparam longint CENTURY_ORIGIN = 2268993;
  localparam longint MARCH_START    = 59;
  localparam longint YEAR_ORIGIN    = 4712;
  localparam longint DAY_MAX        = 4194303;

  // One expected result, one member per output field.
  typedef struct packed {
    logic [12:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [5:0]  clock_second;
  } date_stamp_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [21:0] in_day_number   = '0;
  logic [31:0] in_day_fraction = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [12:0] out_cal_year;
  logic [3:0]  out_cal_month;
  logic [4:0]  out_cal_day;
  logic [4:0]  out_clock_hour;
  logic [5:0]  out_clock_minute;
  logic [5:0]  out_clock_second;

  // Dates predicted for accepted transactions, oldest first.
  date_stamp_t pending_dates[$];
  int          error_count  = 0;
  // When set, neither side inserts random idle cycles.
  bit          steady       = 1'b0;
  // Number of cycles the result side still has to hold out_ready low.
  int          stall_budget = 0;

  julian_day_to_calendar_date_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_day_number    (in_day_number),
    .in_day_fraction  (in_day_fraction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cal_year     (out_cal_year),
    .out_cal_month    (out_cal_month),
    .out_cal_day      (out_cal_day),
    .out_clock_hour   (out_clock_hour),
    .out_clock_minute (out_clock_minute),
    .out_clock_second (out_clock_second)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Division by four that rounds toward minus infinity. The year start of the
  // year before year zero of the count is negative, and a truncating divide
  // would land one day off there.
  function automatic longint floor_by4(input longint num);
    longint q;
    q = num / 4;
    if ((num % 4 != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  // Day count after the Gregorian century correction. Day numbers before the
  // calendar switch are left on the Julian calendar.
  function automatic longint gregorian_count(input logic [21:0] dn);
    longint j;
    longint a;
    j = dn;
    if (j >= GREG_SWITCH) begin
      j = j + 10;
      a = ((j - CENTURY_ORIGIN) * 100) / 3652425;
      j = j + a - (a + 3) / 4;
    end
    return j;
  endfunction

  function automatic date_stamp_t predict_date(input logic [21:0] dn, input logic [31:0] fr);
    longint      j;
    longint      k;
    longint      d;
    longint      m;
    logic [63:0] t;
    date_stamp_t r;
    j = gregorian_count(dn);
    k = (j * 4) / 1461;
    // Offset from the start of the estimated year. When the estimate lands
    // exactly on a year start the offset goes to minus one, which is below
    // the March start like every January and February day, so the day is
    // counted from the previous year start while the year itself stays k.
    d = j - floor_by4(k * 1461) - 1;
    if (d < MARCH_START) d = j - floor_by4((k - 1) * 1461) - 1;
    m = ((d + 64) * 100) / 3061 - 1;
    r.cal_year  = 13'(k - YEAR_ORIGIN);
    r.cal_month = 4'((m > 12) ? m - 12 : m);
    r.cal_day   = 5'(d - (3061 * (m + 1)) / 100 + 64);
    // The clock: the fraction times 24, 60 and 60, truncating each stage.
    t = 64'(fr) * 64'd24;
    r.clock_hour = 5'(t >> 32);
    t = {32'd0, t[31:0]} * 64'd60;
    r.clock_minute = 6'(t >> 32);
    t = {32'd0, t[31:0]} * 64'd60;
    r.clock_second = 6'(t >> 32);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Finds a day number whose corrected count equals target, so that year
  // starts can be hit on the Gregorian side too. Counts skipped by the
  // correction fall back to the target itself.
  function automatic logic [21:0] day_for_count(input longint target);
    for (longint dn = target; dn > target - 64 && dn >= 0; dn--)
      if (gregorian_count(22'(dn)) == target) return 22'(dn);
    return 22'(target);
  endfunction

  // Smallest fraction at which the clock reaches step idx out of units steps
  // per day (24 for hours, 1440 for minutes).
  function automatic logic [31:0] boundary_fraction(input int units, input int idx);
    return 32'(((64'(idx) << 32) + 64'(units) - 64'd1) / 64'(units));
  endfunction

  function automatic logic [21:0] pick_day_number();
    int unsigned mode;
    logic [21:0] base;
    mode = $urandom_range(99);
    if (mode < 55) return 22'($urandom_range(1721424, DAY_MAX));
    if (mode < 75) begin
      // Around a year start, where the previous-year special case lives.
      base = day_for_count(1461 * longint'($urandom_range(1, 2870)));
      return base + 22'($urandom_range(4)) - 22'd2;
    end
    if (mode < 88) return 22'($urandom_range(DAY_MAX));
    if (mode < 94) return 22'(GREG_SWITCH - 8 + $urandom_range(16));
    return $urandom_range(1) ? 22'($urandom_range(7)) : 22'(DAY_MAX - $urandom_range(7));
  endfunction

  function automatic logic [31:0] pick_fraction();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 75) return $urandom();
    if (mode < 85) return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                             : 32'($urandom_range(3));
    if (mode < 93) return boundary_fraction(24, $urandom_range(1, 23)) - $urandom_range(1);
    return boundary_fraction(1440, $urandom_range(1, 1439)) - $urandom_range(1);
  endfunction

  // Offers one timestamp and returns at the edge that accepts it. Outside a
  // steady stretch the sender first idles for a random number of cycles.
  // in_valid stays high on return so back-to-back calls keep the channel full.
  task automatic send_stamp(input logic [21:0] dn, input logic [31:0] fr);
    if (!steady)
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid        <= 1'b1;
    in_day_number   <= dn;
    in_day_fraction <= fr;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(predict_date(dn, fr));
  endtask

  task automatic send_random_stamps(input int count);
    repeat (count) send_stamp(pick_day_number(), pick_fraction());
  endtask

  // Stops offering and waits until every predicted date has come back.
  task automatic await_drain();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Outputs are read at the clock edge, before any update of that edge, and
  // out_ready is driven with a nonblocking assignment, so both sides see the
  // same values the block sees at each edge.
  always @(posedge clk) begin : result_monitor
    date_stamp_t got;
    date_stamp_t want;
    got = '{out_cal_year, out_cal_month, out_cal_day,
            out_clock_hour, out_clock_minute, out_clock_second};
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        report_error("result transaction with no input transaction pending");
      end else begin
        want = pending_dates.pop_front();
        if (got.cal_year !== want.cal_year || got.cal_month !== want.cal_month ||
            got.cal_day !== want.cal_day || got.clock_hour !== want.clock_hour ||
            got.clock_minute !== want.clock_minute ||
            got.clock_second !== want.clock_second)
          report_error($sformatf(
            "mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
            want.cal_year, want.cal_month, want.cal_day, want.clock_hour,
            want.clock_minute, want.clock_second, got.cal_year, got.cal_month,
            got.cal_day, got.clock_hour, got.clock_minute, got.clock_second));
      end
    end
    // A requested hold-off is counted down here, one cycle per edge.
    if (stall_budget > 0) begin
      stall_budget = stall_budget - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both ends of the day number and of the fraction, plus alternating bit
  // patterns so every input bit is seen at both values early on.
  task automatic test_field_extremes();
    send_stamp(22'd0, 32'h0000_0000);
    send_stamp(22'(DAY_MAX), 32'hFFFF_FFFF);
    send_stamp(22'd1721424, 32'h8000_0000);
    send_stamp(22'd1721423, 32'h5555_5555);
    send_stamp(22'h1F_FFFF, 32'hAAAA_AAAA);
    send_stamp(22'd1, 32'h0000_0001);
  endtask

  // The last two Julian days and the first two days that take the century correction.
  task automatic test_calendar_switch();
    for (longint dn = GREG_SWITCH - 2; dn <= GREG_SWITCH + 1; dn++)
      send_stamp(22'(dn), $urandom());
  endtask

  // Day counts that fall exactly on a year start, where the day offset wraps
  // to minus one, on both calendars, plus the two neighbors of the first.
  task automatic test_year_start();
    send_stamp(22'd1753200, $urandom());
    send_stamp(22'd1753199, $urandom());
    send_stamp(22'd1753201, $urandom());
    send_stamp(22'd1723980, $urandom());
    send_stamp(day_for_count(1461 * 1700), $urandom());
    send_stamp(day_for_count(1461 * 2800), $urandom());
  endtask

  // Fractions just at and just below hour and minute boundaries, where the
  // truncation of each stage matters.
  task automatic test_clock_boundaries();
    logic [31:0] b;
    repeat (2) begin
      b = boundary_fraction(24, $urandom_range(1, 23));
      send_stamp(pick_day_number(), b);
      send_stamp(pick_day_number(), b - 32'd1);
    end
    b = boundary_fraction(1440, $urandom_range(1, 1439));
    send_stamp(pick_day_number(), b);
    send_stamp(pick_day_number(), b - 32'd1);
  endtask

  // Bulk random traffic with random idling on both sides.
  task automatic test_random_mix(input int count);
    send_random_stamps(count);
  endtask

  // A long stretch with the input offered and the output taken every cycle.
  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    send_random_stamps(count);
    steady = 1'b0;
  endtask

  // The result side holds off for a long stretch while the sender keeps
  // offering, so the pipeline fills and in_ready must drop until it drains.
  task automatic test_output_backpressure();
    steady       = 1'b1;
    stall_budget = 240;
    send_random_stamps(60);
    steady       = 1'b0;
  endtask

  // Short bursts, each followed by a pause until the block is empty, so the
  // pipeline repeatedly runs dry and restarts.
  task automatic test_drain_pauses();
    repeat (6) begin
      send_random_stamps($urandom_range(3, 12));
      await_drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_calendar_switch();
    test_year_start();
    test_clock_boundaries();
    test_random_mix(1050);
    test_steady_stream(250);
    test_output_backpressure();
    test_drain_pauses();
    await_drain();
    // Give any stray extra result time to show up after the last one.
    repeat (24) @(posedge clk);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
sv/jdc_pkg.sv
sv/jdc_greg.sv
sv/jdc_year.sv
sv/jdc_month.sv
sv/jdc_clock.sv
sv/julian_day_to_calendar_date_unit.sv
tb/sv/tb.sv
